@@ hdl/bdpc_pkg.sv @@
// Shared types, constants and helpers for the button debounce press classifier
`default_nettype none

package bdpc_pkg;

    localparam int TIME_BITS = 32;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 32;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef enum logic [1:0] {
        EVT_NONE  = 2'd0,
        EVT_SHORT = 2'd1,
        EVT_LONG  = 2'd2
    } t_event;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PRESS_LEVEL     = 2'd0,
        REG_DEBOUNCE_TIME   = 2'd1,
        REG_LONG_PRESS_TIME = 2'd2
    } t_reg_index;

    typedef struct packed {
        logic  press_level;
        t_time debounce_time;
        t_time long_press_time;
    } t_cfg;

    localparam logic [31:0] DEBOUNCE_RESET   = 32'd20;
    localparam logic [31:0] LONG_PRESS_RESET = 32'd1000;

    function automatic t_time to_time(input logic [31:0] value);
        logic [63:0] wide;
        wide = {32'd0, value};
        return wide[TIME_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/bdpc_cfg.sv @@
// Configuration register file of the press classifier
`default_nettype none

module bdpc_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [bdpc_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [bdpc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output bdpc_pkg::t_cfg                          o_cfg
);
    import bdpc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_level     <= 1'b0;
            r_cfg.debounce_time   <= to_time(DEBOUNCE_RESET);
            r_cfg.long_press_time <= to_time(LONG_PRESS_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_PRESS_LEVEL:     r_cfg.press_level     <= i_cfg_data[0];
                REG_DEBOUNCE_TIME:   r_cfg.debounce_time   <= to_time(i_cfg_data);
                REG_LONG_PRESS_TIME: r_cfg.long_press_time <= to_time(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ hdl/bdpc_classify.sv @@
// Debounce state and press classification for one registered sample
`default_nettype none

module bdpc_classify (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_raw,
    input  bdpc_pkg::t_time       i_now,
    input  bdpc_pkg::t_cfg        i_cfg,
    output bdpc_pkg::t_event      o_event,
    output logic                  o_pressed
);
    import bdpc_pkg::*;

    logic   r_last_raw;
    t_time  r_change_time;
    logic   r_stable;
    t_time  r_press_time;
    logic   r_long_done;

    logic   n_stable;
    t_time  n_press_time;
    logic   n_long_done;
    t_time  change_time;
    t_time  since_change;
    t_time  held;
    t_event evt;

    always_comb begin
        change_time  = (i_raw != r_last_raw) ? i_now : r_change_time;
        since_change = i_now - change_time;
        held         = i_now - r_press_time;
        n_stable     = r_stable;
        n_press_time = r_press_time;
        n_long_done  = r_long_done;
        evt          = EVT_NONE;
        if (since_change >= i_cfg.debounce_time) begin
            if (i_raw != r_stable) begin
                n_stable = i_raw;
                if (i_raw) begin
                    n_press_time = i_now;
                    n_long_done  = 1'b0;
                end else if (!r_long_done && held != '0) begin
                    evt = EVT_SHORT;
                end
            end else if (r_stable && !r_long_done &&
                         held >= i_cfg.long_press_time) begin
                n_long_done = 1'b1;
                evt         = EVT_LONG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw    <= 1'b0;
            r_change_time <= '0;
            r_stable      <= 1'b0;
            r_press_time  <= '0;
            r_long_done   <= 1'b0;
        end else if (i_en) begin
            r_last_raw    <= i_raw;
            r_change_time <= change_time;
            r_stable      <= n_stable;
            r_press_time  <= n_press_time;
            r_long_done   <= n_long_done;
        end
    end

    assign o_event   = evt;
    assign o_pressed = n_stable;

endmodule

`default_nettype wire

@@ hdl/button_debounce_press_classifier.sv @@
// Top level of the button debounce and short/long press classifier
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid/s_axis_tready    pin_level, now_time
//  m_axis    out        m_axis_tvalid/m_axis_tready    press_event, is_pressed
//  cfg       in         i_cfg_we                       i_cfg_addr, i_cfg_data
//
// One request per cycle while the result is not stalled; an accepted request passes
// through the input register, then classify logic into the result register.
// Synchronous active-low reset empties both registers and clears the state.
// A stalled result holds the output register; the input side keeps taking
// requests as long as the input register can move on.
`default_nettype none

module button_debounce_press_classifier (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [0] pin_level, [32:1] now_time, [39:33] zero
    input  wire logic [bdpc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [1:0] press_event, [2] is_pressed, [7:3] zero
    output logic [bdpc_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    input  wire logic                                i_cfg_we,
    input  wire logic [bdpc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [bdpc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bdpc_pkg::*;

    t_cfg   cfg;
    logic   r_in_valid;
    logic   r_in_raw;
    t_time  r_in_now;
    logic   r_out_valid;
    t_event r_out_event;
    logic   r_out_pressed;
    logic   out_free;
    logic   advance;
    logic   in_ready;
    t_event evt;
    logic   pressed;

    bdpc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign out_free = !r_out_valid || m_axis_tready;
    assign advance  = r_in_valid && out_free;
    assign in_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && s_axis_tvalid) begin
            r_in_raw <= (s_axis_tdata[0] == cfg.press_level);
            r_in_now <= to_time(s_axis_tdata[32:1]);
        end
    end

    bdpc_classify u_classify (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance),
        .i_raw     (r_in_raw),
        .i_now     (r_in_now),
        .i_cfg     (cfg),
        .o_event   (evt),
        .o_pressed (pressed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_event   <= evt;
            r_out_pressed <= pressed;
        end
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_pressed, r_out_event};

endmodule

`default_nettype wire

@@ hdl/bdpc_check.sv @@
// Port-level checks for the press classifier and their binding
`default_nettype none

module bdpc_check (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic [bdpc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import bdpc_pkg::*;

    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("undefined press event code");

    a_short_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == EVT_SHORT) |-> !m_axis_tdata[2])
        else $error("short press reported while still pressed");

    a_long_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == EVT_LONG) |-> m_axis_tdata[2])
        else $error("long press reported while released");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind button_debounce_press_classifier bdpc_check u_bdpc_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the button debounce and short/long press classifier
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bdpc_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int PIPE_CYCLES = 8;

    typedef struct {
        logic  level;
        t_time now;
    } t_button_sample;

    typedef struct {
        t_event evt;
        logic   pressed;
    } t_press_result;

    typedef enum {RX_OPEN, RX_TOGGLE, RX_COIN, RX_SLOW} t_rx_mode;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    button_debounce_press_classifier DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    // classifier copy: configuration and state
    logic  cfg_active   = 1'b0;
    t_time cfg_debounce = DEBOUNCE_RESET;
    t_time cfg_long     = LONG_PRESS_RESET;
    logic  last_raw     = 1'b0;
    t_time change_ms    = '0;
    logic  stable       = 1'b0;
    t_time press_ms     = '0;
    logic  long_done    = 1'b0;

    t_button_sample button_samples[$];
    t_press_result  predicted_events[$];
    int             mismatch_count = 0;
    int             samples_queued = 0;
    t_time          stim_ms;

    function automatic t_press_result classify_sample(logic level, t_time now);
        t_press_result r;
        logic          raw;
        raw = (level == cfg_active);
        r.evt = EVT_NONE;
        if (raw != last_raw) begin
            last_raw = raw;
            change_ms = now;
        end
        if (t_time'(now - change_ms) >= cfg_debounce) begin
            if (raw != stable) begin
                stable = raw;
                if (raw) begin
                    press_ms = now;
                    long_done = 1'b0;
                end else if (!long_done && now != press_ms) begin
                    r.evt = EVT_SHORT;
                end
            end else if (stable && !long_done && t_time'(now - press_ms) >= cfg_long) begin
                long_done = 1'b1;
                r.evt = EVT_LONG;
            end
        end
        r.pressed = stable;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // request driver: bursts separated by random gaps, some of them empty
    t_button_sample on_bus;
    int             gap_left = 0;
    int             burst_left = 1;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted_events.push_back(classify_sample(on_bus.level, on_bus.now));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0 || button_samples.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                    if (gap_left != 0) gap_left--;
                end else begin
                    on_bus = button_samples.pop_front();
                    s_axis_tdata  <= {7'd0, on_bus.now, on_bus.level};
                    s_axis_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // result monitor with its own stall pattern
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;

    always @(posedge i_clk) begin
        t_press_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (predicted_events.size() == 0) begin
                    report_mismatch("unexpected result, tdata", m_axis_tdata, 0);
                end else begin
                    want = predicted_events.pop_front();
                    if (m_axis_tdata[1:0] != want.evt)
                        report_mismatch("press_event", m_axis_tdata[1:0], want.evt);
                    if (m_axis_tdata[2] != want.pressed)
                        report_mismatch("is_pressed", m_axis_tdata[2], want.pressed);
                end
            end
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 96);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_TOGGLE: m_axis_tready <= ~m_axis_tready;
                RX_COIN:   m_axis_tready <= $urandom_range(0, 1);
                default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic add_sample(logic level, t_time now);
        t_button_sample s;
        s.level = level;
        s.now = now;
        button_samples.push_back(s);
        samples_queued++;
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_PRESS_LEVEL:     cfg_active = val[0];
            REG_DEBOUNCE_TIME:   cfg_debounce = val;
            REG_LONG_PRESS_TIME: cfg_long = val;
            default: ;
        endcase
    endtask

    task automatic finish_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (button_samples.size() != 0 || s_axis_tvalid || predicted_events.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_bounces(int unsigned span);
        repeat ($urandom_range(0, 3)) begin
            stim_ms += $urandom_range(0, span);
            add_sample($urandom_range(0, 1), stim_ms);
        end
        stim_ms += $urandom_range(0, span);
    endtask

    task automatic add_press_sequence();
        int unsigned deb;
        int unsigned hold;
        int unsigned n;
        logic        on_lvl;
        t_time       settle_ms;
        deb = cfg_debounce;
        on_lvl = cfg_active;
        add_bounces(deb / 2);
        add_sample(on_lvl, stim_ms);
        settle_ms = stim_ms;
        case ($urandom_range(0, 2))
            0:       hold = $urandom_range(0, cfg_long);
            1:       hold = ((cfg_long > 0) ? cfg_long - 1 : 0) + $urandom_range(0, 2);
            default: hold = 2 * cfg_long + $urandom_range(0, 100);
        endcase
        n = $urandom_range(1, 6);
        for (int i = 1; i <= n; i++)
            add_sample(on_lvl, settle_ms + t_time'((deb + hold) * i / n));
        stim_ms = settle_ms + t_time'(deb + hold);
        add_bounces(deb / 2);
        add_sample(!on_lvl, stim_ms);
        settle_ms = stim_ms;
        hold = $urandom_range(0, 5);
        n = $urandom_range(1, 3);
        for (int i = 1; i <= n; i++)
            add_sample(!on_lvl, settle_ms + t_time'((deb + hold) * i / n));
        stim_ms = settle_ms + t_time'(deb + hold);
    endtask

    task automatic add_noise();
        if ($urandom_range(0, 3) == 0)
            stim_ms = $urandom;
        else
            stim_ms += $urandom_range(0, 2 * cfg_debounce + 3);
        add_sample($urandom_range(0, 1), stim_ms);
    endtask

    task automatic add_random_phase(int count);
        int start;
        start = samples_queued;
        while (samples_queued - start < count) begin
            if ($urandom_range(0, 9) < 8)
                add_press_sequence();
            else
                repeat ($urandom_range(1, 3)) add_noise();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset configuration: bounce, short press, long press, wrap through zero
        add_sample(1'b1, 32'd0);
        add_sample(1'b0, 32'd5);
        add_sample(1'b1, 32'd12);
        add_sample(1'b0, 32'd14);
        add_sample(1'b0, 32'd34);
        add_sample(1'b1, 32'd40);
        add_sample(1'b1, 32'd60);
        add_sample(1'b0, 32'd100);
        add_sample(1'b0, 32'd120);
        add_sample(1'b0, 32'd1119);
        add_sample(1'b0, 32'd1120);
        add_sample(1'b1, 32'd1200);
        add_sample(1'b1, 32'd1220);
        add_sample(1'b0, 32'hFFFF_FFEC);
        add_sample(1'b0, 32'hFFFF_FFFF);
        add_sample(1'b0, 32'd0);
        add_sample(1'b1, 32'd5);
        add_sample(1'b1, 32'd25);
        wait_drained();

        // zero debounce and zero long press time, zero held time
        write_reg(REG_PRESS_LEVEL, 32'd1);
        write_reg(REG_DEBOUNCE_TIME, 32'd0);
        write_reg(REG_LONG_PRESS_TIME, 32'd0);
        finish_writes();
        add_sample(1'b1, 32'd500);
        add_sample(1'b1, 32'd500);
        add_sample(1'b0, 32'd501);
        add_sample(1'b1, 32'd600);
        add_sample(1'b0, 32'd600);
        add_sample(1'b1, 32'd700);
        add_sample(1'b0, 32'd705);
        wait_drained();

        // largest windows, spare index ignored
        write_reg(REG_SPARE, $urandom);
        write_reg(REG_DEBOUNCE_TIME, 32'hFFFF_FFFF);
        write_reg(REG_LONG_PRESS_TIME, 32'hFFFF_FFFF);
        finish_writes();
        add_sample(1'b1, 32'd1000);
        add_sample(1'b1, 32'd999);
        add_sample(1'b1, 32'd998);
        wait_drained();

        stim_ms = $urandom;
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_PRESS_LEVEL, $urandom_range(0, 1));
            write_reg(REG_DEBOUNCE_TIME, (p == 0) ? 0 : $urandom_range(1, 60));
            write_reg(REG_LONG_PRESS_TIME,
                      (p == 1) ? 0 : (p == 2) ? $urandom_range(1, 5) : $urandom_range(20, 600));
            finish_writes();
            if (p == 3) begin
                add_random_phase(50);
                wait_drained();
                @(negedge i_clk);
                add_random_phase(55);
            end else begin
                add_random_phase(105);
            end
            wait_drained();
        end

        if (mismatch_count == 0 && predicted_events.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
